FILE: rtl/nab_pkg.sv
// Shared types and constants of the 3x3 neighbour average blur.
package nab_pkg;

	// One RGB pixel.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// One column of the two row stores, kept side by side in one memory word.
	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_entry_t;

	// Meaning of the input word's user bit.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	// Register widths and reset values.
	localparam int unsigned FRAME_WIDTH_W  = 11;
	localparam int unsigned FRAME_HEIGHT_W = 13;
	localparam int unsigned CFG_DATA_W     = 13;
	localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

endpackage

FILE: rtl/nab_line_store.sv
// Row store memory holding the two rows above the input row, with write-to-read forwarding.
module nab_line_store #(
	parameter int unsigned DEPTH  = 1024,
	parameter int unsigned ADDR_W = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [ADDR_W-1:0]    rd_addr,
	output nab_pkg::line_entry_t rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  nab_pkg::line_entry_t wr_data
);

	nab_pkg::line_entry_t mem [DEPTH];
	nab_pkg::line_entry_t mem_rd_q;
	nab_pkg::line_entry_t fwd_data_q;
	logic                 fwd_q;

	// The memory returns the old contents when a read meets a write to the same
	// entry, so the written word is kept aside and chosen instead.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : mem_rd_q;

endmodule

FILE: rtl/neighbour_average_blur_3x3_unit.sv
// Top level of the streaming 3x3 neighbour average blur for RGB frames.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------------------
//   s_*     | in        | s_tvalid / s_tready  | tdata: red, green, blue; tuser: command
//   m_*     | out       | m_tvalid / m_tready  | tdata: red, green, blue; tlast: frame end
//   cfg_*   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (frame width, height)
//
// The unit takes one word per clock unless the sink holds the output, and gives at
// most one word per clock. An accepted word passes through the registered read
// of the row store memory, then the window update and the output register.
// Reset clears the position counters, the window and the pipeline; the row store
// memory is not cleared, as entries that were never written never reach an output.
// When the output word is held by the sink, the input side is held as well, so
// no word is lost; the output register keeps the two sides apart otherwise.
module neighbour_average_blur_3x3_unit #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [23:0]                         s_tdata,  // [7:0] in_red, [15:8] in_green, [23:16] in_blue
	input  logic                                s_tuser,  // [0] command
	// Output stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [23:0]                         m_tdata,  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
	output logic                                m_tlast,  // frame_end
	// Configuration writes.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nab_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [nab_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Column counters index the row store; row counters must reach one past the
	// frame height while the drain words run.
	localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
	localparam int unsigned OROW_W = $clog2(MAX_HEIGHT);
	localparam int unsigned IROW_W = $clog2(MAX_HEIGHT + 2);

	// Configuration registers, held raw and clamped where they are used.
	logic [nab_pkg::FRAME_WIDTH_W-1:0]  frame_width_q;
	logic [nab_pkg::FRAME_HEIGHT_W-1:0] frame_height_q;
	logic                               cfg_wr;

	// Stream position.
	logic [COL_W-1:0]  in_col_q;
	logic [IROW_W-1:0] in_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [OROW_W-1:0] out_row_q;

	// Front end decisions, taken in the cycle a word is accepted.
	logic [31:0] fw_ext, fh_ext, eff_w, eff_h;
	logic [31:0] in_col_ext, in_row_ext, out_col_ext, out_row_ext;
	logic [31:0] in_col_inc, out_col_inc;
	logic        flushing, launch, due, border, last, in_wrap, out_wrap, adv;
	nab_pkg::pix_t in_pix;

	// Second stage: the word whose row store data is being read out.
	logic             v_s1;
	logic [COL_W-1:0] col_s1;
	nab_pkg::pix_t    pix_s1;
	logic             due_s1, border_s1, last_s1;

	nab_pkg::line_entry_t rd_entry, wr_entry;

	// Window: row 0 is the upper row, column 2 the newest column.
	nab_pkg::pix_t win_q [3][3];
	nab_pkg::pix_t win_d [3][3];

	// Output register.
	logic          out_valid_q;
	logic          out_last_q;
	nab_pkg::pix_t out_pix_q;
	nab_pkg::pix_t blur_pix;

	// Sum over the eight neighbours of one channel, each divided by eight first.
	// The largest sum is 8 * 31, so eight bits always hold it.
	function automatic logic [7:0] neighbour_sum(input logic [7:0] vals [9]);
		logic [7:0] acc;
		acc = 8'd0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4) begin
				acc = acc + {3'b000, vals[i][7:3]};
			end
		end
		return acc;
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// The whole pipeline moves when the output register is free or being emptied.
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	always_comb begin
		fw_ext = 32'(frame_width_q);
		fh_ext = 32'(frame_height_q);
		if (fw_ext == 32'd0) begin
			eff_w = 32'd1;
		end else if (fw_ext > 32'(MAX_WIDTH)) begin
			eff_w = 32'(MAX_WIDTH);
		end else begin
			eff_w = fw_ext;
		end
		if (fh_ext == 32'd0) begin
			eff_h = 32'd1;
		end else if (fh_ext > 32'(MAX_HEIGHT)) begin
			eff_h = 32'(MAX_HEIGHT);
		end else begin
			eff_h = fh_ext;
		end

		in_col_ext  = 32'(in_col_q);
		in_row_ext  = 32'(in_row_q);
		out_col_ext = 32'(out_col_q);
		out_row_ext = 32'(out_row_q);

		// Once every pixel of the frame is in, any word drives the drain.
		flushing = in_row_ext >= eff_h;
		// A drain word before the frame's last pixel is taken and dropped.
		launch   = s_tvalid && s_tready && !((s_tuser == nab_pkg::CMD_DRAIN) && !flushing);

		in_pix.red   = flushing ? 8'd0 : s_tdata[7:0];
		in_pix.green = flushing ? 8'd0 : s_tdata[15:8];
		in_pix.blue  = flushing ? 8'd0 : s_tdata[23:16];

		// An output is due once a row and one pixel have gone in.
		due = (in_row_ext >= 32'd2) || ((in_row_ext == 32'd1) && (in_col_ext >= 32'd1));

		in_col_inc  = in_col_ext + 32'd1;
		in_wrap     = in_col_inc >= eff_w;
		out_col_inc = out_col_ext + 32'd1;
		out_wrap    = out_col_inc >= eff_w;

		border = (out_row_ext == 32'd0) || (out_row_ext >= eff_h - 32'd1)
			|| (out_col_ext == 32'd0) || (out_col_ext >= eff_w - 32'd1);
		last   = (out_row_ext >= eff_h - 32'd1) && (out_col_ext >= eff_w - 32'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= nab_pkg::FRAME_WIDTH_RST;
			frame_height_q <= nab_pkg::FRAME_HEIGHT_RST;
			in_col_q       <= '0;
			in_row_q       <= '0;
			out_col_q      <= '0;
			out_row_q      <= '0;
		end else if (cfg_wr) begin
			// A write to the frame width or frame height register restarts the stream at the top left pixel.
			if (cfg_index == nab_pkg::CFG_FRAME_WIDTH) begin
				frame_width_q <= cfg_data[nab_pkg::FRAME_WIDTH_W-1:0];
			end
			if (cfg_index == nab_pkg::CFG_FRAME_HEIGHT) begin
				frame_height_q <= cfg_data[nab_pkg::FRAME_HEIGHT_W-1:0];
			end
			if ((cfg_index == nab_pkg::CFG_FRAME_WIDTH) ||
			    (cfg_index == nab_pkg::CFG_FRAME_HEIGHT)) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end
		end else if (launch) begin
			if (due && last) begin
				// The frame's final output: every counter returns to the start.
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q <= in_wrap ? '0 : COL_W'(in_col_inc);
				in_row_q <= in_wrap ? IROW_W'(in_row_ext + 32'd1) : in_row_q;
				if (due) begin
					out_col_q <= out_wrap ? '0 : COL_W'(out_col_inc);
					out_row_q <= out_wrap ? OROW_W'(out_row_ext + 32'd1) : out_row_q;
				end
			end
		end
	end

	// Payload of the second stage needs no reset.
	always_ff @(posedge clk) begin
		if (launch) begin
			col_s1    <= in_col_q;
			pix_s1    <= in_pix;
			due_s1    <= due;
			border_s1 <= border;
			last_s1   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= launch;
		end
	end

	// The column read for the accepted word is written back as it leaves the second
	// stage: the middle row moves up and the new pixel becomes the middle row.
	assign wr_entry.upper  = rd_entry.middle;
	assign wr_entry.middle = pix_s1;

	nab_line_store #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (launch),
		.rd_addr (in_col_q),
		.rd_data (rd_entry),
		.wr_en   (adv && v_s1),
		.wr_addr (col_s1),
		.wr_data (wr_entry)
	);

	// Window after the shift that this word brings.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_d[r][0] = win_q[r][1];
			win_d[r][1] = win_q[r][2];
		end
		win_d[0][2] = rd_entry.upper;
		win_d[1][2] = rd_entry.middle;
		win_d[2][2] = pix_s1;
	end

	always_comb begin
		logic [7:0] reds [9];
		logic [7:0] greens [9];
		logic [7:0] blues [9];
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				reds[r*3+c]   = win_d[r][c].red;
				greens[r*3+c] = win_d[r][c].green;
				blues[r*3+c]  = win_d[r][c].blue;
			end
		end
		blur_pix.red   = neighbour_sum(reds);
		blur_pix.green = neighbour_sum(greens);
		blur_pix.blue  = neighbour_sum(blues);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (adv && v_s1) begin
			win_q <= win_d;
		end
	end

	// Border pixels pass the window centre through unchanged.
	always_ff @(posedge clk) begin
		if (adv && v_s1 && due_s1) begin
			out_pix_q  <= border_s1 ? win_d[1][1] : blur_pix;
			out_last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && v_s1 && due_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_pix_q.blue, out_pix_q.green, out_pix_q.red};
	assign m_tlast  = out_last_q;

endmodule

FILE: rtl/nab_checker.sv
// Port-level checks of the blur unit, attached to it by a bind statement.
module nab_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [23:0]                     m_tdata,
	input logic                            m_tlast,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);

	// A held output word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// With the output register empty the input side must be open.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output register");

	// A new output word must follow an accepted input word.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output word without a matching input word");

	// Configuration writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind neighbour_average_blur_3x3_unit nab_checker u_nab_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
